@@ rtl/core/rpv_pkg.sv @@
package rpv_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;

  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FORCE_GAIN = 3'd0;
  localparam cfg_idx_t REG_CENTER_X   = 3'd1;
  localparam cfg_idx_t REG_CENTER_Y   = 3'd2;
  localparam cfg_idx_t REG_CENTER_Z   = 3'd3;
  localparam cfg_idx_t REG_RADIUS     = 3'd4;
  localparam cfg_idx_t REG_ENABLE     = 3'd5;

endpackage

@@ rtl/core/particle_point_repel_velocity_top.sv @@
// Point repulsor with linear falloff on a stream of particles.
// Each input transaction carries one particle's position, velocity and time
// step; each output transaction carries the updated velocity and a pushed
// flag. Both channels use valid and ready. Exactly one result leaves for
// every particle taken, in order.
// The configuration channel writes force gain, center, radius and enable;
// it is always ready and should be used only while the pipeline is empty.
// The pipeline has three front stages, one square root stage per root bit,
// one divider stage per quotient bit, four scaling stages and the output
// register. It takes one particle per cycle unless the output stalls.
// Every stage holds its own valid bit, so a stalled receiver fills the
// empty stages first and input ready falls only once the pipeline is full.
// Synchronous reset empties the pipeline and restores the register defaults:
// force gain 1.0, center at the origin, radius 1.0 and repulsion enabled.
module particle_point_repel_velocity_top
  import rpv_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [WORD_WIDTH-1:0] in_pos_x,
  input  logic signed [WORD_WIDTH-1:0] in_pos_y,
  input  logic signed [WORD_WIDTH-1:0] in_pos_z,
  input  logic signed [WORD_WIDTH-1:0] in_vel_x,
  input  logic signed [WORD_WIDTH-1:0] in_vel_y,
  input  logic signed [WORD_WIDTH-1:0] in_vel_z,
  input  logic        [WORD_WIDTH-2:0] in_time_step,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WORD_WIDTH-1:0] out_new_vel_x,
  output logic signed [WORD_WIDTH-1:0] out_new_vel_y,
  output logic signed [WORD_WIDTH-1:0] out_new_vel_z,
  output logic                         out_pushed,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  cfg_idx_t                     cfg_index,
  input  logic        [WORD_WIDTH-1:0] cfg_data
);

  localparam int W      = WORD_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int UW     = W - 1;
  localparam int SQW    = 2 * UW;
  localparam int QW     = F + 1;
  localparam int DV_W   = 3 + 3 * W + UW + 1;
  localparam int SQ_W   = 3 * UW + DV_W;
  localparam int S2_W   = 2 * W - 1 - F;
  localparam int LO_W   = (S2_W + 1) / 2;
  localparam int HI_W   = S2_W - LO_W;
  localparam int FULL_W = S2_W + QW;
  localparam int DW_W   = FULL_W - F;

  // Configuration registers.
  logic [W-1:0]  force_gain_r;
  logic [W-1:0]  center_r [3];
  logic [UW-1:0] radius_r;
  logic          enable_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_gain_r <= W'(1) << F;
      center_r[0]  <= '0;
      center_r[1]  <= '0;
      center_r[2]  <= '0;
      radius_r     <= UW'(1) << F;
      enable_r     <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FORCE_GAIN: force_gain_r <= cfg_data;
        REG_CENTER_X:   center_r[0]  <= cfg_data;
        REG_CENTER_Y:   center_r[1]  <= cfg_data;
        REG_CENTER_Z:   center_r[2]  <= cfg_data;
        REG_RADIUS:     radius_r     <= cfg_data[UW-1:0];
        REG_ENABLE:     enable_r     <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  logic en_a, en_b, en_c, en_d, en_e, en_f, en_g, en_h;
  logic sq_in_ready, sq_out_valid, dv_in_ready, dv_out_valid;

  // Stage A: offsets from the center and the per-axis bound check.
  logic [W-1:0]  pos   [3];
  logic [W-1:0]  vel   [3];
  logic          v_a_r;
  logic [UW-1:0] a_am_r  [3];
  logic          a_sgn_r [3];
  logic [W-1:0]  a_vel_r [3];
  logic [UW-1:0] a_dt_r;
  logic          a_in_r;
  logic [UW-1:0] a_am_nxt  [3];
  logic          a_sgn_nxt [3];
  logic          a_in_nxt;

  assign pos[0] = in_pos_x;
  assign pos[1] = in_pos_y;
  assign pos[2] = in_pos_z;
  assign vel[0] = in_vel_x;
  assign vel[1] = in_vel_y;
  assign vel[2] = in_vel_z;

  always_comb begin
    logic [W:0] dif;
    logic [W:0] mg;
    a_in_nxt = enable_r;
    for (int i = 0; i < 3; i++) begin
      dif          = {pos[i][W-1], pos[i]} - {center_r[i][W-1], center_r[i]};
      mg           = dif[W] ? (~dif + 1'b1) : dif;
      a_sgn_nxt[i] = dif[W];
      a_am_nxt[i]  = mg[UW-1:0];
      if (mg >= {2'b00, radius_r}) begin
        a_in_nxt = 1'b0;
      end
    end
  end

  assign in_ready = en_a;
  assign en_a     = !v_a_r || en_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (en_a) begin
      v_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int i = 0; i < 3; i++) begin
        a_am_r[i]  <= a_am_nxt[i];
        a_sgn_r[i] <= a_sgn_nxt[i];
        a_vel_r[i] <= vel[i];
      end
      a_dt_r <= in_time_step;
      a_in_r <= a_in_nxt;
    end
  end

  // Stage B: squares of the offsets and of the radius.
  logic           v_b_r;
  logic [SQW-1:0] b_sq_r  [3];
  logic [SQW-1:0] b_r2_r;
  logic [UW-1:0]  b_am_r  [3];
  logic           b_sgn_r [3];
  logic [W-1:0]   b_vel_r [3];
  logic [UW-1:0]  b_dt_r;
  logic           b_in_r;

  assign en_b = !v_b_r || en_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
    end else if (en_b) begin
      v_b_r <= v_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      for (int i = 0; i < 3; i++) begin
        b_sq_r[i]  <= SQW'(a_am_r[i]) * SQW'(a_am_r[i]);
        b_am_r[i]  <= a_am_r[i];
        b_sgn_r[i] <= a_sgn_r[i];
        b_vel_r[i] <= a_vel_r[i];
      end
      b_r2_r <= SQW'(radius_r) * SQW'(radius_r);
      b_dt_r <= a_dt_r;
      b_in_r <= a_in_r;
    end
  end

  // Stage C: squared distance and the inside test.
  logic           v_c_r;
  logic [SQW-1:0] c_d2_r;
  logic [UW-1:0]  c_am_r  [3];
  logic           c_sgn_r [3];
  logic [W-1:0]   c_vel_r [3];
  logic [UW-1:0]  c_dt_r;
  logic           c_in_r;
  logic [SQW+1:0] c_sum;
  logic           c_in_nxt;

  assign c_sum    = (SQW+2)'(b_sq_r[0]) + (SQW+2)'(b_sq_r[1]) + (SQW+2)'(b_sq_r[2]);
  assign c_in_nxt = b_in_r && (c_sum < (SQW+2)'(b_r2_r)) && (c_sum != '0);
  assign en_c     = !v_c_r || sq_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else if (en_c) begin
      v_c_r <= v_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      for (int i = 0; i < 3; i++) begin
        c_am_r[i]  <= b_am_r[i];
        c_sgn_r[i] <= b_sgn_r[i];
        c_vel_r[i] <= b_vel_r[i];
      end
      c_d2_r <= c_sum[SQW-1:0];
      c_dt_r <= b_dt_r;
      c_in_r <= c_in_nxt;
    end
  end

  // Square root of the squared distance.
  logic [DV_W-1:0] c_dv_side;
  logic [SQ_W-1:0] sq_side_i, sq_side_o;
  logic [UW-1:0]   sq_root;

  assign c_dv_side = {c_sgn_r[0], c_sgn_r[1], c_sgn_r[2],
                      c_vel_r[0], c_vel_r[1], c_vel_r[2], c_dt_r, c_in_r};
  assign sq_side_i = {c_am_r[0], c_am_r[1], c_am_r[2], c_dv_side};

  rpv_sqrt #(
    .ROOT_W (UW),
    .SIDE_W (SQ_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_c_r),
    .in_ready  (sq_in_ready),
    .in_rad    (c_d2_r),
    .in_side   (sq_side_i),
    .out_valid (sq_out_valid),
    .out_ready (dv_in_ready),
    .out_root  (sq_root),
    .out_side  (sq_side_o)
  );

  // Falloff fraction and unit direction, four divider lanes.
  logic [3:0][UW-1:0] dv_num, dv_den;
  logic [3:0][F:0]    dv_quo;
  logic [DV_W-1:0]    dv_side_o;

  assign dv_num[0] = radius_r - sq_root;
  assign dv_den[0] = radius_r;
  assign dv_num[1] = sq_side_o[SQ_W-1 -: UW];
  assign dv_num[2] = sq_side_o[SQ_W-1-UW -: UW];
  assign dv_num[3] = sq_side_o[SQ_W-1-2*UW -: UW];
  assign dv_den[1] = sq_root;
  assign dv_den[2] = sq_root;
  assign dv_den[3] = sq_root;

  rpv_div #(
    .DEN_W     (UW),
    .FRAC_BITS (F),
    .LANES     (4),
    .SIDE_W    (DV_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_out_valid),
    .in_ready  (dv_in_ready),
    .in_num    (dv_num),
    .in_den    (dv_den),
    .in_side   (sq_side_o[DV_W-1:0]),
    .out_valid (dv_out_valid),
    .out_ready (en_d),
    .out_quo   (dv_quo),
    .out_side  (dv_side_o)
  );

  logic          dv_sgn [3];
  logic [W-1:0]  dv_vel [3];
  logic [UW-1:0] dv_dt;
  logic          dv_in;

  assign dv_in     = dv_side_o[0];
  assign dv_dt     = dv_side_o[UW:1];
  assign dv_vel[2] = dv_side_o[UW+W:UW+1];
  assign dv_vel[1] = dv_side_o[UW+2*W:UW+W+1];
  assign dv_vel[0] = dv_side_o[UW+3*W:UW+2*W+1];
  assign dv_sgn[2] = dv_side_o[UW+3*W+1];
  assign dv_sgn[1] = dv_side_o[UW+3*W+2];
  assign dv_sgn[0] = dv_side_o[UW+3*W+3];

  // Stage D: force gain times falloff.
  logic          v_d_r;
  logic [W-1:0]  d_s1_r;
  logic [F:0]    d_u_r   [3];
  logic          d_neg_r [3];
  logic [W-1:0]  d_vel_r [3];
  logic [UW-1:0] d_dt_r;
  logic          d_in_r;
  logic [W-1:0]  fg_mag;
  logic [W+F:0]  d_prod;

  assign fg_mag = force_gain_r[W-1] ? (~force_gain_r + 1'b1) : force_gain_r;
  assign d_prod = (W+F+1)'(fg_mag) * (W+F+1)'(dv_quo[0]);
  assign en_d   = !v_d_r || en_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d_r <= 1'b0;
    end else if (en_d) begin
      v_d_r <= dv_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      for (int i = 0; i < 3; i++) begin
        d_u_r[i]   <= dv_quo[i+1];
        d_neg_r[i] <= force_gain_r[W-1] ^ dv_sgn[i];
        d_vel_r[i] <= dv_vel[i];
      end
      d_s1_r <= d_prod[W+F-1:F];
      d_dt_r <= dv_dt;
      d_in_r <= dv_in;
    end
  end

  // Stage E: scale by the time step.
  logic            v_e_r;
  logic [S2_W-1:0] e_s2_r;
  logic [F:0]      e_u_r   [3];
  logic            e_neg_r [3];
  logic [W-1:0]    e_vel_r [3];
  logic            e_in_r;
  logic [2*W-2:0]  e_prod;

  assign e_prod = (2*W-1)'(d_s1_r) * (2*W-1)'(d_dt_r);
  assign en_e   = !v_e_r || en_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_e_r <= 1'b0;
    end else if (en_e) begin
      v_e_r <= v_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      for (int i = 0; i < 3; i++) begin
        e_u_r[i]   <= d_u_r[i];
        e_neg_r[i] <= d_neg_r[i];
        e_vel_r[i] <= d_vel_r[i];
      end
      e_s2_r <= e_prod[2*W-2:F];
      e_in_r <= d_in_r;
    end
  end

  // Stage F: partial products of the step size and each direction.
  logic               v_f_r;
  logic [LO_W+F:0]    f_plo_r [3];
  logic [HI_W+F:0]    f_phi_r [3];
  logic               f_neg_r [3];
  logic [W-1:0]       f_vel_r [3];
  logic               f_in_r;

  assign en_f = !v_f_r || en_g;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f_r <= 1'b0;
    end else if (en_f) begin
      v_f_r <= v_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      for (int i = 0; i < 3; i++) begin
        f_plo_r[i] <= (LO_W+F+1)'(e_s2_r[LO_W-1:0]) * (LO_W+F+1)'(e_u_r[i]);
        f_phi_r[i] <= (HI_W+F+1)'(e_s2_r[S2_W-1:LO_W]) * (HI_W+F+1)'(e_u_r[i]);
        f_neg_r[i] <= e_neg_r[i];
        f_vel_r[i] <= e_vel_r[i];
      end
      f_in_r <= e_in_r;
    end
  end

  // Stage G: combine, clamp the magnitude and apply the sign.
  logic           v_g_r;
  logic [W:0]     g_delta_r [3];
  logic [W-1:0]   g_vel_r   [3];
  logic           g_in_r;
  logic [W:0]     g_delta_nxt [3];

  always_comb begin
    logic [FULL_W-1:0] full;
    logic [DW_W-1:0]   dw;
    logic [W-1:0]      dm;
    for (int i = 0; i < 3; i++) begin
      full = (FULL_W'(f_phi_r[i]) << LO_W) + FULL_W'(f_plo_r[i]);
      dw   = full[FULL_W-1:F];
      dm   = (dw > (DW_W'(1) << (W - 1))) ? (W'(1) << (W - 1)) : dw[W-1:0];
      g_delta_nxt[i] = f_neg_r[i] ? (~{1'b0, dm} + 1'b1) : {1'b0, dm};
    end
  end

  assign en_g = !v_g_r || en_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_g_r <= 1'b0;
    end else if (en_g) begin
      v_g_r <= v_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_g) begin
      for (int i = 0; i < 3; i++) begin
        g_delta_r[i] <= g_delta_nxt[i];
        g_vel_r[i]   <= f_vel_r[i];
      end
      g_in_r <= f_in_r;
    end
  end

  // Stage H: saturating add into the output register.
  logic         out_valid_r;
  logic [W-1:0] out_vel_r [3];
  logic         out_pushed_r;
  logic [W-1:0] h_vel_nxt [3];

  always_comb begin
    logic [W+1:0] s;
    for (int i = 0; i < 3; i++) begin
      s = {{2{g_vel_r[i][W-1]}}, g_vel_r[i]} + {g_delta_r[i][W], g_delta_r[i]};
      if (!g_in_r) begin
        h_vel_nxt[i] = g_vel_r[i];
      end else if (s[W+1] && (s[W:W-1] != 2'b11)) begin
        h_vel_nxt[i] = {1'b1, {(W-1){1'b0}}};
      end else if (!s[W+1] && (s[W:W-1] != 2'b00)) begin
        h_vel_nxt[i] = {1'b0, {(W-1){1'b1}}};
      end else begin
        h_vel_nxt[i] = s[W-1:0];
      end
    end
  end

  assign en_h = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_h) begin
      out_valid_r <= v_g_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_h) begin
      for (int i = 0; i < 3; i++) begin
        out_vel_r[i] <= h_vel_nxt[i];
      end
      out_pushed_r <= g_in_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_vel_x = out_vel_r[0];
  assign out_new_vel_y = out_vel_r[1];
  assign out_new_vel_z = out_vel_r[2];
  assign out_pushed    = out_pushed_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v_a_r |-> in_ready)
    else $error("input not ready while the first stage is empty");

  a_disabled_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !enable_r) |=> (v_a_r && !a_in_r))
    else $error("particle marked inside while repulsion is disabled");

  a_outside_stays_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v_b_r && en_c && !b_in_r) |=> !c_in_r)
    else $error("inside flag set after failing the bound check");

  a_pushed_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (v_g_r && en_h) |=> (out_valid && (out_pushed == $past(g_in_r))))
    else $error("pushed flag lost between the last stages");

endmodule

@@ rtl/core/rpv_sqrt.sv @@
module rpv_sqrt #(
  parameter int ROOT_W = 31,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2*ROOT_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROOT_W-1:0]     out_root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int RAD_W = 2 * ROOT_W;

  logic              v_r    [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rem_r  [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];
  logic              en     [ROOT_W+1];

  assign en[ROOT_W] = out_ready;
  assign in_ready   = en[0];
  assign out_valid  = v_r[ROOT_W-1];
  assign out_root   = root_r[ROOT_W-1];
  assign out_side   = side_r[ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic              v_p;
    logic [ROOT_W-1:0] root_p;
    logic [RAD_W-1:0]  rem_p;
    logic [SIDE_W-1:0] side_p;
    logic [RAD_W-1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign root_p = '0;
      assign rem_p  = in_rad;
      assign side_p = in_side;
    end else begin : g_next
      assign v_p    = v_r[k-1];
      assign root_p = root_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign side_p = side_r[k-1];
    end

    assign en[k] = !v_r[k] || en[k+1];
    assign trial = (RAD_W'(root_p) << (B + 1)) | (RAD_W'(1) << (2 * B));
    assign take  = rem_p >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        root_r[k] <= take ? (root_p | (ROOT_W'(1) << B)) : root_p;
        rem_r[k]  <= take ? (rem_p - trial) : rem_p;
        side_r[k] <= side_p;
      end
    end
  end

endmodule

@@ rtl/core/rpv_div.sv @@
module rpv_div #(
  parameter int DEN_W     = 31,
  parameter int FRAC_BITS = 16,
  parameter int LANES     = 4,
  parameter int SIDE_W    = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [LANES-1:0][DEN_W-1:0]     in_num,
  input  logic [LANES-1:0][DEN_W-1:0]     in_den,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [LANES-1:0][FRAC_BITS:0]   out_quo,
  output logic [SIDE_W-1:0]               out_side
);

  localparam int NS  = FRAC_BITS + 1;
  localparam int Q_W = FRAC_BITS + 1;

  logic              v_r    [NS];
  logic [DEN_W-1:0]  rem_r  [NS][LANES];
  logic [DEN_W-1:0]  den_r  [NS][LANES];
  logic [Q_W-1:0]    q_r    [NS][LANES];
  logic [SIDE_W-1:0] side_r [NS];
  logic              en     [NS+1];

  assign en[NS]    = out_ready;
  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign out_side  = side_r[NS-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo[l] = q_r[NS-1][l];
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic              v_p;
    logic [DEN_W-1:0]  rem_p [LANES];
    logic [DEN_W-1:0]  den_p [LANES];
    logic [Q_W-1:0]    q_p   [LANES];
    logic [SIDE_W-1:0] side_p;
    logic [DEN_W-1:0]  rem_n [LANES];
    logic [Q_W-1:0]    q_n   [LANES];

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign side_p = in_side;
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_p[l] = in_num[l];
          den_p[l] = in_den[l];
          q_p[l]   = '0;
        end
      end
    end else begin : g_next
      assign v_p    = v_r[k-1];
      assign side_p = side_r[k-1];
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_p[l] = rem_r[k-1][l];
          den_p[l] = den_r[k-1][l];
          q_p[l]   = q_r[k-1][l];
        end
      end
    end

    assign en[k] = !v_r[k] || en[k+1];

    always_comb begin
      logic [DEN_W:0] t;
      logic [DEN_W:0] dif;
      logic           take;
      for (int l = 0; l < LANES; l++) begin
        t        = (k == 0) ? {1'b0, rem_p[l]} : {rem_p[l], 1'b0};
        dif      = t - {1'b0, den_p[l]};
        take     = t >= {1'b0, den_p[l]};
        rem_n[l] = take ? dif[DEN_W-1:0] : t[DEN_W-1:0];
        q_n[l]   = {q_p[l][Q_W-2:0], take};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        side_r[k] <= side_p;
        for (int l = 0; l < LANES; l++) begin
          rem_r[k][l] <= rem_n[l];
          den_r[k][l] <= den_p[l];
          q_r[k][l]   <= q_n[l];
        end
      end
    end
  end

endmodule
